>>> rtl/core/cds_pkg.sv
// shared types, constants and calendar functions for the date stepper
package cds_pkg;

   localparam int OP_W       = 2;
   localparam int STEP_W     = 10;
   localparam int DAY_W      = 5;
   localparam int MONTH_W    = 4;
   localparam int YEAR_W     = 14;
   localparam int DOY_W      = 9;
   localparam int SERIAL_W   = 22;
   localparam int ERR_W      = 2;
   localparam int Q100_W     = 8;
   localparam int MOD100_W   = 7;
   localparam int CENT_W     = 2;
   localparam int RECIP_W    = 13;
   localparam int PROD_W     = YEAR_W + RECIP_W;

   localparam int MAX_YEAR       = 9999;
   localparam int MAX_STEP       = 1023;
   localparam int RECIP100       = 5243;
   localparam int RECIP100_SHIFT = 19;
   localparam int DAYS_PER_YEAR  = 365;
   localparam int YEARS_PER_CENT = 100;

   localparam logic [MONTH_W-1:0] MONTH_JAN = MONTH_W'(1);
   localparam logic [MONTH_W-1:0] MONTH_FEB = MONTH_W'(2);
   localparam logic [MONTH_W-1:0] MONTH_DEC = MONTH_W'(12);
   localparam logic [DAY_W-1:0]   DAY_FIRST = DAY_W'(1);
   localparam logic [DAY_W-1:0]   DAY_LAST  = DAY_W'(31);

   typedef enum logic [OP_W-1:0] {
      OP_LOAD = 2'd0,
      OP_FWD  = 2'd1,
      OP_BWD  = 2'd2,
      OP_NONE = 2'd3
   } op_type;

   typedef enum logic [ERR_W-1:0] {
      ERR_OK    = 2'd0,
      ERR_LOAD  = 2'd1,
      ERR_LIMIT = 2'd2
   } err_type;

   typedef struct packed {
      logic accept;
      logic ld_mult;
      logic ld_check;
      logic ld_serial;
      logic step;
      logic finish;
   } cmd_type;

   typedef struct packed {
      op_type op;
      logic   cnt_zero;
      logic   at_limit;
   } status_type;

   function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                  input logic leap);
      logic [DAY_W-1:0] len;
      case (m) inside
         4'd4, 4'd6, 4'd9, 4'd11: len = DAY_W'(30);
         MONTH_FEB:                len = leap ? DAY_W'(29) : DAY_W'(28);
         default:                  len = DAY_W'(31);
      endcase
      return len;
   endfunction

   // days in the months before m, february counted as 28
   function automatic logic [DOY_W-1:0] cum_days(input logic [MONTH_W-1:0] m);
      logic [DOY_W-1:0] d;
      case (m)
         4'd1:    d = DOY_W'(0);
         4'd2:    d = DOY_W'(31);
         4'd3:    d = DOY_W'(59);
         4'd4:    d = DOY_W'(90);
         4'd5:    d = DOY_W'(120);
         4'd6:    d = DOY_W'(151);
         4'd7:    d = DOY_W'(181);
         4'd8:    d = DOY_W'(212);
         4'd9:    d = DOY_W'(243);
         4'd10:   d = DOY_W'(273);
         4'd11:   d = DOY_W'(304);
         4'd12:   d = DOY_W'(334);
         default: d = DOY_W'(0);
      endcase
      return d;
   endfunction

   // year mod 100 and century mod 4 give the leap rule
   function automatic logic is_leap(input logic [MOD100_W-1:0] mod100,
                                    input logic [CENT_W-1:0] cent4);
      return (mod100[1:0] == 2'd0) && ((mod100 != '0) || (cent4 == '0));
   endfunction

endpackage

>>> rtl/core/cds_if.sv
// request and response channel interfaces
interface cds_req_if;
   import cds_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [OP_W-1:0]      op;
   logic [STEP_W-1:0]    step_days;
   logic [DAY_W-1:0]     load_day;
   logic [MONTH_W-1:0]   load_month;
   logic [YEAR_W-1:0]    load_year;
   modport source (output valid, op, step_days, load_day, load_month, load_year,
                   input ready);
   modport sink (input valid, op, step_days, load_day, load_month, load_year,
                 output ready);
endinterface

interface cds_rsp_if;
   import cds_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [DAY_W-1:0]     out_day;
   logic [MONTH_W-1:0]   out_month;
   logic [YEAR_W-1:0]    out_year;
   logic [DOY_W-1:0]     day_of_year;
   logic [SERIAL_W-1:0]  serial_day;
   logic [ERR_W-1:0]     error;
   modport source (output valid, out_day, out_month, out_year, day_of_year,
                   serial_day, error, input ready);
   modport sink (input valid, out_day, out_month, out_year, day_of_year,
                 serial_day, error, output ready);
endinterface

>>> rtl/core/calendar_date_stepper_core.sv
// top level of the gregorian date stepper
//
//   channel   dir   handshake      carries
//   req_chan  in    valid/ready    op, step_days, load_day, load_month, load_year
//   rsp_chan  out   valid/ready    out_day, out_month, out_year, day_of_year,
//                                  serial_day, error
//
// one transaction at a time; a step moves one day per cycle through the day
// counter, a load runs the multiply, check and serial states, op 3 goes to finish
// reset returns the date to 1/1/1 and drops any pending response
// the response register lets the next request in while the last response waits;
// a new response is only written once the old one has been taken
module calendar_date_stepper_core (
   input  logic      clock,
   input  logic      reset,
   cds_req_if.sink   req_chan,
   cds_rsp_if.source rsp_chan
);
   import cds_pkg::*;

   cmd_type    cmd;
   status_type status;

   cds_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   cds_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_op          (req_chan.op),
      .req_step_days   (req_chan.step_days),
      .req_load_day    (req_chan.load_day),
      .req_load_month  (req_chan.load_month),
      .req_load_year   (req_chan.load_year),
      .rsp_out_day     (rsp_chan.out_day),
      .rsp_out_month   (rsp_chan.out_month),
      .rsp_out_year    (rsp_chan.out_year),
      .rsp_day_of_year (rsp_chan.day_of_year),
      .rsp_serial_day  (rsp_chan.serial_day),
      .rsp_error       (rsp_chan.error)
   );

endmodule

>>> rtl/core/cds_ctrl.sv
// sequencing state machine for the date stepper
module cds_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  cds_pkg::status_type status,
   output cds_pkg::cmd_type    cmd
);
   import cds_pkg::*;

   typedef enum logic [6:0] {
      ST_IDLE      = 7'b0000001,
      ST_DISPATCH  = 7'b0000010,
      ST_LD_MULT   = 7'b0000100,
      ST_LD_CHECK  = 7'b0001000,
      ST_LD_SERIAL = 7'b0010000,
      ST_STEP      = 7'b0100000,
      ST_FINISH    = 7'b1000000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      fire;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      fire     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            case (status.op)
               OP_LOAD: state_in = ST_LD_MULT;
               OP_FWD:  state_in = ST_STEP;
               OP_BWD:  state_in = ST_STEP;
               default: state_in = ST_FINISH;
            endcase
         end
         ST_LD_MULT: begin
            cmd.ld_mult = 1'b1;
            state_in    = ST_LD_CHECK;
         end
         ST_LD_CHECK: begin
            cmd.ld_check = 1'b1;
            state_in     = ST_LD_SERIAL;
         end
         ST_LD_SERIAL: begin
            cmd.ld_serial = 1'b1;
            state_in      = ST_FINISH;
         end
         ST_STEP: begin
            cmd.step = 1'b1;
            if (status.cnt_zero || status.at_limit) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            fire = !rsp_valid_ff || rsp_ready;
            if (fire) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      rsp_valid_in = (rsp_valid_ff && !rsp_ready) || fire;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

>>> rtl/core/cds_dp.sv
// date registers, day stepping, load check and serial day arithmetic
module cds_dp (
   input  logic                           clock,
   input  logic                           reset,
   input  cds_pkg::cmd_type               cmd,
   output cds_pkg::status_type            status,
   input  logic [cds_pkg::OP_W-1:0]       req_op,
   input  logic [cds_pkg::STEP_W-1:0]     req_step_days,
   input  logic [cds_pkg::DAY_W-1:0]      req_load_day,
   input  logic [cds_pkg::MONTH_W-1:0]    req_load_month,
   input  logic [cds_pkg::YEAR_W-1:0]     req_load_year,
   output logic [cds_pkg::DAY_W-1:0]      rsp_out_day,
   output logic [cds_pkg::MONTH_W-1:0]    rsp_out_month,
   output logic [cds_pkg::YEAR_W-1:0]     rsp_out_year,
   output logic [cds_pkg::DOY_W-1:0]      rsp_day_of_year,
   output logic [cds_pkg::SERIAL_W-1:0]   rsp_serial_day,
   output logic [cds_pkg::ERR_W-1:0]      rsp_error
);
   import cds_pkg::*;

   // latched transaction
   op_type               op_ff, op_in;
   logic [STEP_W-1:0]    cnt_ff, cnt_in;
   logic [DAY_W-1:0]     ld_day_ff, ld_day_in;
   logic [MONTH_W-1:0]   ld_month_ff, ld_month_in;
   logic [YEAR_W-1:0]    ld_year_ff, ld_year_in;
   logic [Q100_W-1:0]    q100_ff, q100_in;
   logic [SERIAL_W-1:0]  y365_ff, y365_in;
   err_type              err_ff, err_in;

   // held date and derived counters
   logic [DAY_W-1:0]     day_ff, day_in;
   logic [MONTH_W-1:0]   month_ff, month_in;
   logic [YEAR_W-1:0]    year_ff, year_in;
   logic [MOD100_W-1:0]  mod100_ff, mod100_in;
   logic [CENT_W-1:0]    cent4_ff, cent4_in;
   logic [DOY_W-1:0]     doy_ff, doy_in;
   logic [SERIAL_W-1:0]  serial_ff, serial_in;

   // response register
   logic [DAY_W-1:0]     out_day_ff, out_day_in;
   logic [MONTH_W-1:0]   out_month_ff, out_month_in;
   logic [YEAR_W-1:0]    out_year_ff, out_year_in;
   logic [DOY_W-1:0]     out_doy_ff, out_doy_in;
   logic [SERIAL_W-1:0]  out_serial_ff, out_serial_in;
   logic [ERR_W-1:0]     out_err_ff, out_err_in;

   logic                 leap_cur, leap_dec, leap_ld;
   logic [MOD100_W-1:0]  mod100_inc, mod100_dec, ld_mod100;
   logic [CENT_W-1:0]    cent4_inc, cent4_dec;
   logic [DAY_W-1:0]     mlen_cur, mlen_prev;
   logic                 fwd_limit, bwd_limit, ld_ok;
   logic [PROD_W-1:0]    q_prod;
   logic [YEAR_W-1:0]    cent_part;
   logic                 early;
   logic [YEAR_W-1:0]    y_adj;
   logic [Q100_W-1:0]    q_adj;
   logic [SERIAL_W-1:0]  leaps;

   always_comb begin
      leap_cur   = is_leap(mod100_ff, cent4_ff);
      mod100_inc = (mod100_ff == MOD100_W'(YEARS_PER_CENT - 1)) ? '0 : mod100_ff + 1'b1;
      cent4_inc  = (mod100_ff == MOD100_W'(YEARS_PER_CENT - 1)) ? cent4_ff + 1'b1 : cent4_ff;
      mod100_dec = (mod100_ff == '0) ? MOD100_W'(YEARS_PER_CENT - 1) : mod100_ff - 1'b1;
      cent4_dec  = (mod100_ff == '0) ? cent4_ff - 1'b1 : cent4_ff;
      leap_dec   = is_leap(mod100_dec, cent4_dec);
      mlen_cur   = month_len(month_ff, leap_cur);
      mlen_prev  = month_len(month_ff - 1'b1, leap_cur);
      fwd_limit  = (year_ff >= YEAR_W'(MAX_YEAR)) && (month_ff == MONTH_DEC) &&
                   (day_ff == DAY_LAST);
      bwd_limit  = (year_ff <= YEAR_W'(1)) && (month_ff == MONTH_JAN) &&
                   (day_ff == DAY_FIRST);

      // load path
      q_prod    = PROD_W'(ld_year_ff) * PROD_W'(RECIP100);
      cent_part = YEAR_W'(q100_ff) * YEAR_W'(YEARS_PER_CENT);
      ld_mod100 = MOD100_W'(ld_year_ff - cent_part);
      leap_ld   = is_leap(ld_mod100, q100_ff[CENT_W-1:0]);
      ld_ok     = (ld_month_ff >= MONTH_JAN) && (ld_month_ff <= MONTH_DEC) &&
                  (ld_year_ff != '0) && (ld_year_ff <= YEAR_W'(MAX_YEAR)) &&
                  (ld_day_ff >= DAY_FIRST) &&
                  (ld_day_ff <= month_len(ld_month_ff, leap_ld));

      // leap days before the date, counted up to the previous year for jan and feb
      early = (month_ff <= MONTH_FEB);
      y_adj = year_ff - YEAR_W'(early);
      q_adj = q100_ff - Q100_W'(early && (mod100_ff == '0));
      leaps = SERIAL_W'(y_adj >> 2) - SERIAL_W'(q_adj) + SERIAL_W'(q_adj >> 2);

      op_in         = op_ff;
      cnt_in        = cnt_ff;
      ld_day_in     = ld_day_ff;
      ld_month_in   = ld_month_ff;
      ld_year_in    = ld_year_ff;
      q100_in       = q100_ff;
      y365_in       = y365_ff;
      err_in        = err_ff;
      day_in        = day_ff;
      month_in      = month_ff;
      year_in       = year_ff;
      mod100_in     = mod100_ff;
      cent4_in      = cent4_ff;
      doy_in        = doy_ff;
      serial_in     = serial_ff;
      out_day_in    = out_day_ff;
      out_month_in  = out_month_ff;
      out_year_in   = out_year_ff;
      out_doy_in    = out_doy_ff;
      out_serial_in = out_serial_ff;
      out_err_in    = out_err_ff;

      if (cmd.accept) begin
         op_in       = op_type'(req_op);
         cnt_in      = (int'(req_step_days) > MAX_STEP) ? STEP_W'(MAX_STEP) : req_step_days;
         ld_day_in   = req_load_day;
         ld_month_in = req_load_month;
         ld_year_in  = req_load_year;
         err_in      = ERR_OK;
      end

      if (cmd.ld_mult) begin
         q100_in = Q100_W'(q_prod >> RECIP100_SHIFT);
         y365_in = SERIAL_W'(ld_year_ff) * SERIAL_W'(DAYS_PER_YEAR);
      end

      if (cmd.ld_check) begin
         if (ld_ok) begin
            day_in    = ld_day_ff;
            month_in  = ld_month_ff;
            year_in   = ld_year_ff;
            mod100_in = ld_mod100;
            cent4_in  = q100_ff[CENT_W-1:0];
         end else begin
            err_in = ERR_LOAD;
         end
      end

      if (cmd.ld_serial && (err_ff == ERR_OK)) begin
         serial_in = y365_ff + SERIAL_W'(day_ff) + SERIAL_W'(cum_days(month_ff)) +
                     leaps - SERIAL_W'(DAYS_PER_YEAR);
         doy_in    = DOY_W'(day_ff) - 1'b1 + cum_days(month_ff) +
                     DOY_W'(leap_cur && (month_ff > MONTH_FEB));
      end

      if (cmd.step && (cnt_ff != '0)) begin
         if (status.at_limit) begin
            err_in = ERR_LIMIT;
         end else begin
            cnt_in = cnt_ff - 1'b1;
            if (op_ff == OP_FWD) begin
               serial_in = serial_ff + 1'b1;
               doy_in    = doy_ff + 1'b1;
               if (day_ff < mlen_cur) begin
                  day_in = day_ff + 1'b1;
               end else begin
                  day_in = DAY_FIRST;
                  if (month_ff >= MONTH_DEC) begin
                     month_in  = MONTH_JAN;
                     year_in   = year_ff + 1'b1;
                     mod100_in = mod100_inc;
                     cent4_in  = cent4_inc;
                     doy_in    = '0;
                  end else begin
                     month_in = month_ff + 1'b1;
                  end
               end
            end else begin
               serial_in = serial_ff - 1'b1;
               doy_in    = doy_ff - 1'b1;
               if (day_ff > DAY_FIRST) begin
                  day_in = day_ff - 1'b1;
               end else if (month_ff <= MONTH_JAN) begin
                  month_in  = MONTH_DEC;
                  day_in    = DAY_LAST;
                  year_in   = year_ff - 1'b1;
                  mod100_in = mod100_dec;
                  cent4_in  = cent4_dec;
                  doy_in    = leap_dec ? DOY_W'(DAYS_PER_YEAR) : DOY_W'(DAYS_PER_YEAR - 1);
               end else begin
                  month_in = month_ff - 1'b1;
                  day_in   = mlen_prev;
               end
            end
         end
      end

      if (cmd.finish) begin
         out_day_in    = day_ff;
         out_month_in  = month_ff;
         out_year_in   = year_ff;
         out_doy_in    = doy_ff;
         out_serial_in = serial_ff;
         out_err_in    = err_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         day_ff    <= DAY_FIRST;
         month_ff  <= MONTH_JAN;
         year_ff   <= YEAR_W'(1);
         mod100_ff <= MOD100_W'(1);
         cent4_ff  <= '0;
         doy_ff    <= '0;
         serial_ff <= SERIAL_W'(1);
         op_ff     <= OP_NONE;
         cnt_ff    <= '0;
         err_ff    <= ERR_OK;
      end else begin
         day_ff    <= day_in;
         month_ff  <= month_in;
         year_ff   <= year_in;
         mod100_ff <= mod100_in;
         cent4_ff  <= cent4_in;
         doy_ff    <= doy_in;
         serial_ff <= serial_in;
         op_ff     <= op_in;
         cnt_ff    <= cnt_in;
         err_ff    <= err_in;
      end
   end

   always_ff @(posedge clock) begin
      ld_day_ff     <= ld_day_in;
      ld_month_ff   <= ld_month_in;
      ld_year_ff    <= ld_year_in;
      q100_ff       <= q100_in;
      y365_ff       <= y365_in;
      out_day_ff    <= out_day_in;
      out_month_ff  <= out_month_in;
      out_year_ff   <= out_year_in;
      out_doy_ff    <= out_doy_in;
      out_serial_ff <= out_serial_in;
      out_err_ff    <= out_err_in;
   end

   assign status.op       = op_ff;
   assign status.cnt_zero = (cnt_ff == '0);
   assign status.at_limit = (op_ff == OP_FWD) ? fwd_limit : bwd_limit;

   assign rsp_out_day     = out_day_ff;
   assign rsp_out_month   = out_month_ff;
   assign rsp_out_year    = out_year_ff;
   assign rsp_day_of_year = out_doy_ff;
   assign rsp_serial_day  = out_serial_ff;
   assign rsp_error       = out_err_ff;

endmodule
